[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the private key import block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/depki_pkg.sv]
// ---------------------------------------------------------------------------
// depki_pkg
// Types, constants and the group order table for the key import block.
// ---------------------------------------------------------------------------
`default_nettype none

package depki_pkg;

	localparam logic [7:0] SEQ_TAG_BYTE   = 8'h30;
	localparam logic [7:0] LONG_LEN_FLAG  = 8'h80;
	localparam logic [7:0] VER_TAG_BYTE   = 8'h02;
	localparam logic [7:0] VER_ONE_BYTE   = 8'h01;
	localparam logic [7:0] OCT_TAG_BYTE   = 8'h04;
	localparam logic [7:0] KEY_BYTES      = 8'd32;
	localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;

	typedef enum logic [1:0] {
		CMP_EQUAL   = 2'd0,
		CMP_LESS    = 2'd1,
		CMP_GREATER = 2'd2
	} cmp_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       final_byte;
	} req_t;

	typedef struct packed {
		logic        key_ok;
		logic [63:0] key_word_top;
		logic [63:0] key_word_upper_mid;
		logic [63:0] key_word_lower_mid;
		logic [63:0] key_word_bottom;
	} rsp_t;

	// Byte of the secp256k1 group order, index 0 the most significant.
	function automatic logic [7:0] order_byte(input logic [4:0] idx);
		logic [7:0] b;
		unique case (idx)
			5'd15:   b = 8'hFE;
			5'd16:   b = 8'hBA;
			5'd17:   b = 8'hAE;
			5'd18:   b = 8'hDC;
			5'd19:   b = 8'hE6;
			5'd20:   b = 8'hAF;
			5'd21:   b = 8'h48;
			5'd22:   b = 8'hA0;
			5'd23:   b = 8'h3B;
			5'd24:   b = 8'hBF;
			5'd25:   b = 8'hD2;
			5'd26:   b = 8'h5E;
			5'd27:   b = 8'h8C;
			5'd28:   b = 8'hD0;
			5'd29:   b = 8'h36;
			5'd30:   b = 8'h41;
			5'd31:   b = 8'h41;
			default: b = 8'hFF;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/depki_parser.sv]
// ---------------------------------------------------------------------------
// depki_parser
// Byte-wise layout checker, key shift register and running order compare.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module depki_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire depki_pkg::req_t item,
	output depki_pkg::rsp_t    result
);
	import depki_pkg::*;

	typedef enum logic [3:0] {
		PH_SEQ_TAG   = 4'd0,
		PH_LEN_CTL   = 4'd1,
		PH_LEN_BYTES = 4'd2,
		PH_VER0      = 4'd3,
		PH_VER1      = 4'd4,
		PH_VER2      = 4'd5,
		PH_OCT_TAG   = 4'd6,
		PH_OCT_LEN   = 4'd7,
		PH_KEY       = 4'd8,
		PH_DONE      = 4'd9
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [1:0]   len_cnt_q, len_cnt_d;
	logic [15:0]  seq_len_q, seq_len_d;
	logic [16:0]  after_len_q, after_len_d;
	logic [5:0]   oct_len_q, oct_len_d;
	logic [5:0]   key_seen_q, key_seen_d;
	logic [255:0] key_q, key_d;
	cmp_t         cmp_q, cmp_d;
	logic         nonzero_q, nonzero_d;
	logic         format_error_q, format_error_d;

	logic [7:0]   b;
	logic [6:0]   len_sel;
	logic [5:0]   idx_full;
	logic [7:0]   ref_byte;
	logic         ok;

	assign b        = item.byte_value;
	assign len_sel  = b[6:0];
	assign idx_full = key_seen_q - oct_len_q;
	assign ref_byte = order_byte(idx_full[4:0]);

	always_comb begin
		phase_d        = phase_q;
		len_cnt_d      = len_cnt_q;
		seq_len_d      = seq_len_q;
		after_len_d    = after_len_q;
		oct_len_d      = oct_len_q;
		key_seen_d     = key_seen_q;
		key_d          = key_q;
		cmp_d          = cmp_q;
		nonzero_d      = nonzero_q;
		format_error_d = format_error_q;

		if (!format_error_q) begin
			if (phase_q >= PH_VER0 && phase_q <= PH_DONE && after_len_q != COUNT_MAX) begin
				after_len_d = after_len_q + 17'd1;
			end
			unique case (phase_q)
				PH_SEQ_TAG: begin
					if (b != SEQ_TAG_BYTE) format_error_d = 1'b1;
					else phase_d = PH_LEN_CTL;
				end
				PH_LEN_CTL: begin
					if ((b & LONG_LEN_FLAG) == 8'd0 || len_sel < 7'd1 || len_sel > 7'd2) begin
						format_error_d = 1'b1;
					end else begin
						len_cnt_d = len_sel[1:0];
						seq_len_d = '0;
						phase_d   = PH_LEN_BYTES;
					end
				end
				PH_LEN_BYTES: begin
					seq_len_d = {seq_len_q[7:0], b};
					len_cnt_d = len_cnt_q - 2'd1;
					if (len_cnt_d == 2'd0) phase_d = PH_VER0;
				end
				PH_VER0: begin
					if (b != VER_TAG_BYTE) format_error_d = 1'b1;
					else phase_d = PH_VER1;
				end
				PH_VER1: begin
					if (b != VER_ONE_BYTE) format_error_d = 1'b1;
					else phase_d = PH_VER2;
				end
				PH_VER2: begin
					if (b != VER_ONE_BYTE) format_error_d = 1'b1;
					else phase_d = PH_OCT_TAG;
				end
				PH_OCT_TAG: begin
					if (b != OCT_TAG_BYTE) format_error_d = 1'b1;
					else phase_d = PH_OCT_LEN;
				end
				PH_OCT_LEN: begin
					if (b > KEY_BYTES) begin
						format_error_d = 1'b1;
					end else begin
						oct_len_d  = b[5:0];
						key_seen_d = '0;
						cmp_d      = (b < KEY_BYTES) ? CMP_LESS : CMP_EQUAL;
						phase_d    = (b == 8'd0) ? PH_DONE : PH_KEY;
					end
				end
				PH_KEY: begin
					key_d = {key_q[247:0], b};
					if (b != 8'd0) nonzero_d = 1'b1;
					if (cmp_q == CMP_EQUAL) begin
						if (b < ref_byte) cmp_d = CMP_LESS;
						else if (b > ref_byte) cmp_d = CMP_GREATER;
					end
					key_seen_d = key_seen_q + 6'd1;
					if (key_seen_d >= oct_len_q) phase_d = PH_DONE;
				end
				PH_DONE: begin
				end
				default: format_error_d = 1'b1;
			endcase
		end

		// The result reflects the state after the final byte has been taken.
		ok = !format_error_d && phase_d == PH_DONE && after_len_d >= {1'b0, seq_len_d}
			&& nonzero_d && cmp_d == CMP_LESS;
		result.key_ok             = ok;
		result.key_word_top       = ok ? key_d[255:192] : 64'd0;
		result.key_word_upper_mid = ok ? key_d[191:128] : 64'd0;
		result.key_word_lower_mid = ok ? key_d[127:64]  : 64'd0;
		result.key_word_bottom    = ok ? key_d[63:0]    : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SEQ_TAG;
			len_cnt_q      <= '0;
			seq_len_q      <= '0;
			after_len_q    <= '0;
			oct_len_q      <= '0;
			key_seen_q     <= '0;
			key_q          <= '0;
			cmp_q          <= CMP_EQUAL;
			nonzero_q      <= 1'b0;
			format_error_q <= 1'b0;
		end else if (step) begin
			if (item.final_byte) begin
				phase_q        <= PH_SEQ_TAG;
				len_cnt_q      <= '0;
				seq_len_q      <= '0;
				after_len_q    <= '0;
				oct_len_q      <= '0;
				key_seen_q     <= '0;
				key_q          <= '0;
				cmp_q          <= CMP_EQUAL;
				nonzero_q      <= 1'b0;
				format_error_q <= 1'b0;
			end else begin
				phase_q        <= phase_d;
				len_cnt_q      <= len_cnt_d;
				seq_len_q      <= seq_len_d;
				after_len_q    <= after_len_d;
				oct_len_q      <= oct_len_d;
				key_seen_q     <= key_seen_d;
				key_q          <= key_d;
				cmp_q          <= cmp_d;
				nonzero_q      <= nonzero_d;
				format_error_q <= format_error_d;
			end
		end
	end

	`ASSERT_NEXT(a_final_clears, clk, arst_n, step && item.final_byte,
		phase_q == PH_SEQ_TAG && !format_error_q && key_q == '0)
	`ASSERT_IMPLIES(a_key_count_bound, clk, arst_n, phase_q == PH_KEY,
		key_seen_q < oct_len_q)

endmodule

`default_nettype wire

[rtl/der_ec_private_key_import_unit.sv]
// Data path: a byte transfer lands in the input register; the result of a final byte
// is loaded into the output register when it is free and held on rsp until it is taken.
// Throughput: one byte per cycle; the input stalls only while a final byte waits behind
// an unread result in the output register.
// Reset: arst_n clears the parse state, key register and both valid flags at once.
// ---------------------------------------------------------------------------
// der_ec_private_key_import_unit
// Streaming import of a DER-encoded secp256k1 private key with range check.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module der_ec_private_key_import_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire depki_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output depki_pkg::rsp_t      rsp
);
	import depki_pkg::*;

	// Input register: one byte waiting to be folded into the parse state.
	logic   in_valid_s1;
	req_t   in_s1;

	// Output register: the result of the last final byte.
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic   s1_adv;
	logic   step;
	rsp_t   result;

	// A byte that is not final never produces a result, so it always moves on.
	// A final byte needs the output register to be empty or emptying this cycle.
	assign s1_adv    = !in_s1.final_byte || !rsp_valid_q || rsp_ready;
	assign step      = in_valid_s1 && s1_adv;
	assign req_ready = !in_valid_s1 || s1_adv;

	depki_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			in_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			in_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step && in_s1.final_byte) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_s1.final_byte) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The input stalls only behind a final byte whose result has nowhere to go.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !req_ready,
		in_valid_s1 && in_s1.final_byte && rsp_valid_q && !rsp_ready)
	// A failed import never exposes key material.
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, rsp_valid_q && !rsp_q.key_ok,
		rsp_q.key_word_top == 64'd0 && rsp_q.key_word_upper_mid == 64'd0
		&& rsp_q.key_word_lower_mid == 64'd0 && rsp_q.key_word_bottom == 64'd0)
	// An accepted key is never zero.
	`ASSERT_IMPLIES(a_ok_nonzero, clk, arst_n, rsp_valid_q && rsp_q.key_ok,
		rsp_q.key_word_top != 64'd0 || rsp_q.key_word_upper_mid != 64'd0
		|| rsp_q.key_word_lower_mid != 64'd0 || rsp_q.key_word_bottom != 64'd0)

endmodule

`default_nettype wire

[tb/sv/der_ec_private_key_import_unit_test.sv]
// ---------------------------------------------------------------------------
// der_ec_private_key_import_unit_test
// Byte-stream test of the private key import block: encodings go in one
// transfer per byte, and every key result is checked field by field
// against an in-bench parser.
// ---------------------------------------------------------------------------
module der_ec_private_key_import_unit_test;
	import depki_pkg::*;

	// The run is stopped here if the block wedges.
	localparam int CYCLE_LIMIT = 200000;

	// Order of the secp256k1 group, most significant byte first.
	localparam logic [255:0] GROUP_ORDER =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;

	// Where the in-bench parser stands in the layout.
	typedef enum logic [3:0] {
		STEP_SEQ_TAG,
		STEP_LEN_CTL,
		STEP_LEN_BYTES,
		STEP_VER0,
		STEP_VER1,
		STEP_VER2,
		STEP_OCT_TAG,
		STEP_OCT_LEN,
		STEP_KEY,
		STEP_DONE
	} parse_step_t;

	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Idling odds in percent, changed from phase to phase.
	int idle_pct = 0;
	int stall_pct = 0;
	int fault_count = 0;
	int cycle_count = 0;

	// Key results that the parser has worked out and the block still owes.
	rsp_t key_results[$];

	// State of the in-bench parser.
	parse_step_t parse_step;
	logic [1:0] len_bytes_left;
	logic [15:0] seq_length;
	logic [16:0] tail_count;
	logic [5:0] octet_len;
	logic [5:0] key_taken;
	logic [255:0] key_value;
	cmp_t order_state;
	logic key_seen_nonzero;
	logic layout_bad;

	der_ec_private_key_import_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// The result side takes or refuses a transfer at random, with the odds set
	// by the current phase. A stall of zero percent keeps ready high throughout.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a wedged handshake must not hang the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("der_ec_private_key_import_unit: mismatch");
			$finish;
		end
	end

	function automatic logic [7:0] order_at(input int idx);
		return GROUP_ORDER[255 - 8 * idx -: 8];
	endfunction

	task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("key import check: %s expected %h got %h", what, want, got);
	endtask

	// Result checker. Outputs are sampled at the rising edge, before any
	// update that edge causes, so a transfer seen here is one the block made.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (key_results.size() == 0) begin
				note_fault("unexpected result, key_ok", '0, 64'(rsp.key_ok));
			end else begin
				want = key_results.pop_front();
				if (rsp.key_ok !== want.key_ok)
					note_fault("key_ok", 64'(want.key_ok), 64'(rsp.key_ok));
				if (rsp.key_word_top !== want.key_word_top)
					note_fault("key_word_top", want.key_word_top, rsp.key_word_top);
				if (rsp.key_word_upper_mid !== want.key_word_upper_mid)
					note_fault("key_word_upper_mid", want.key_word_upper_mid,
						rsp.key_word_upper_mid);
				if (rsp.key_word_lower_mid !== want.key_word_lower_mid)
					note_fault("key_word_lower_mid", want.key_word_lower_mid,
						rsp.key_word_lower_mid);
				if (rsp.key_word_bottom !== want.key_word_bottom)
					note_fault("key_word_bottom", want.key_word_bottom, rsp.key_word_bottom);
			end
		end
	end

	task automatic clear_parse();
		parse_step = STEP_SEQ_TAG;
		len_bytes_left = '0;
		seq_length = '0;
		tail_count = '0;
		octet_len = '0;
		key_taken = '0;
		key_value = '0;
		order_state = CMP_EQUAL;
		key_seen_nonzero = 1'b0;
		layout_bad = 1'b0;
	endtask

	// Advances the parser by one byte. Once the layout is broken every byte
	// up to the final one is ignored.
	task automatic absorb_byte(input logic [7:0] b);
		logic [7:0] limit;
		if (layout_bad)
			return;
		// Every byte past the length field counts toward the sequence length
		// check, trailing bytes included.
		if (parse_step >= STEP_VER0 && tail_count != COUNT_MAX)
			tail_count = tail_count + 17'd1;
		case (parse_step)
			STEP_SEQ_TAG: begin
				if (b != SEQ_TAG_BYTE) layout_bad = 1'b1;
				else parse_step = STEP_LEN_CTL;
			end
			STEP_LEN_CTL: begin
				// Only the long form with one or two length bytes is accepted.
				if ((b & LONG_LEN_FLAG) == 8'd0 || b[6:0] < 7'd1 || b[6:0] > 7'd2) begin
					layout_bad = 1'b1;
				end else begin
					len_bytes_left = b[1:0];
					seq_length = '0;
					parse_step = STEP_LEN_BYTES;
				end
			end
			STEP_LEN_BYTES: begin
				seq_length = {seq_length[7:0], b};
				len_bytes_left = len_bytes_left - 2'd1;
				if (len_bytes_left == 2'd0)
					parse_step = STEP_VER0;
			end
			STEP_VER0: begin
				if (b != VER_TAG_BYTE) layout_bad = 1'b1;
				else parse_step = STEP_VER1;
			end
			STEP_VER1: begin
				if (b != VER_ONE_BYTE) layout_bad = 1'b1;
				else parse_step = STEP_VER2;
			end
			STEP_VER2: begin
				if (b != VER_ONE_BYTE) layout_bad = 1'b1;
				else parse_step = STEP_OCT_TAG;
			end
			STEP_OCT_TAG: begin
				if (b != OCT_TAG_BYTE) layout_bad = 1'b1;
				else parse_step = STEP_OCT_LEN;
			end
			STEP_OCT_LEN: begin
				if (b > KEY_BYTES) begin
					layout_bad = 1'b1;
				end else begin
					octet_len = b[5:0];
					key_taken = '0;
					// A short key is left-padded with zeros, so it is below the
					// order from the start; a full one is compared byte by byte.
					order_state = (b < KEY_BYTES) ? CMP_LESS : CMP_EQUAL;
					parse_step = (b == 8'd0) ? STEP_DONE : STEP_KEY;
				end
			end
			STEP_KEY: begin
				key_value = {key_value[247:0], b};
				if (b != 8'd0)
					key_seen_nonzero = 1'b1;
				if (order_state == CMP_EQUAL) begin
					limit = order_at(32 - int'(octet_len) + int'(key_taken));
					if (b < limit) order_state = CMP_LESS;
					else if (b > limit) order_state = CMP_GREATER;
				end
				key_taken = key_taken + 6'd1;
				if (key_taken >= octet_len)
					parse_step = STEP_DONE;
			end
			STEP_DONE: begin
			end
			default: layout_bad = 1'b1;
		endcase
	endtask

	// Called for every accepted byte. The final byte is parsed first; then the
	// key result is queued and the parser starts over.
	task automatic take_item(input logic [7:0] b, input logic fin);
		rsp_t want;
		logic ok;
		absorb_byte(b);
		if (fin) begin
			ok = !layout_bad && parse_step == STEP_DONE && {1'b0, seq_length} <= tail_count
				&& key_seen_nonzero && order_state == CMP_LESS;
			want.key_ok = ok;
			want.key_word_top = ok ? key_value[255:192] : '0;
			want.key_word_upper_mid = ok ? key_value[191:128] : '0;
			want.key_word_lower_mid = ok ? key_value[127:64] : '0;
			want.key_word_bottom = ok ? key_value[63:0] : '0;
			key_results = {key_results, want};
			clear_parse();
		end
	endtask

	// Sends one byte. Valid stays high from one transfer to the next unless
	// the sender chooses to idle, so valid is never dropped and raised in the
	// same step.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{byte_value: b, final_byte: fin};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		take_item(b, fin);
	endtask

	task automatic send_stream(input byte_q_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	// Holds the sender off until the block has delivered every key result.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (key_results.size() != 0);
	endtask

	function automatic byte_q_t rand_key(input int n);
		byte_q_t key;
		repeat (n)
			key = {key, (($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)))};
		return key;
	endfunction

	// A 32-byte key that agrees with the group order in its first k bytes and
	// lands just below, on, just above it or at random at byte k. With k of 32
	// the key equals the order.
	function automatic byte_q_t near_order_key(input int k);
		byte_q_t key;
		logic [7:0] o;
		for (int i = 0; i < 32; i++) begin
			o = order_at(i);
			if (i < k) begin
				key = {key, o};
			end else if (i == k) begin
				case ($urandom_range(3))
					0: key = {key, 8'(o - 8'd1)};
					1: key = {key, 8'(o + 8'd1)};
					2: key = {key, o};
					default: key = {key, 8'($urandom_range(255))};
				endcase
			end else begin
				key = {key, 8'($urandom_range(255))};
			end
		end
		return key;
	endfunction

	// Builds a well-formed encoding around a key. The sequence length covers
	// the body exactly, shifted by len_adj; two length bytes are used when
	// asked for or when the length does not fit in one.
	function automatic byte_q_t der_blob(input byte_q_t key, input int trail_n,
			input int len_adj, input bit two_len);
		byte_q_t s;
		int body;
		logic [15:0] len16;
		body = 5 + key.size() + trail_n + len_adj;
		if (body < 0) body = 0;
		if (body > 65535) body = 65535;
		len16 = 16'(body);
		s = {s, SEQ_TAG_BYTE};
		if (two_len || body > 255) begin
			s = {s, LONG_LEN_FLAG | 8'd2};
			s = {s, len16[15:8]};
		end else begin
			s = {s, LONG_LEN_FLAG | 8'd1};
		end
		s = {s, len16[7:0]};
		s = {s, VER_TAG_BYTE};
		s = {s, VER_ONE_BYTE};
		s = {s, VER_ONE_BYTE};
		s = {s, OCT_TAG_BYTE};
		s = {s, 8'(key.size())};
		foreach (key[i])
			s = {s, key[i]};
		repeat (trail_n)
			s = {s, 8'($urandom_range(255))};
		return s;
	endfunction

	// Keys that sit at the edges of the valid range, and the length check.
	task automatic test_accepted_keys();
		byte_q_t key;
		byte_q_t none;
		// One below the order: the largest valid key.
		key = near_order_key(32);
		key[31] = key[31] - 8'd1;
		send_stream(der_blob(key, 0, 0, 1'b0));
		// The order itself and an all-ones key are both out of range.
		send_stream(der_blob(near_order_key(32), 0, 0, 1'b0));
		key = {};
		repeat (32) key = {key, 8'hFF};
		send_stream(der_blob(key, 0, 0, 1'b1));
		// Smallest nonzero key, and a one-byte key with every bit set.
		send_stream(der_blob('{8'h01}, 0, 0, 1'b0));
		send_stream(der_blob('{8'hFF}, 0, 0, 1'b1));
		// A zero key, written out in full and as an empty octet string.
		key = {};
		repeat (32) key = {key, 8'h00};
		send_stream(der_blob(key, 0, 0, 1'b0));
		send_stream(der_blob(none, 0, 0, 1'b0));
		// Length one past what follows fails; a length of zero passes.
		send_stream(der_blob(rand_key(3), 0, 1, 1'b0));
		send_stream(der_blob('{8'h5A, 8'hA5}, 0, -100, 1'b0));
		// Largest two-byte length, far beyond the buffer.
		send_stream(der_blob('{8'h11}, 0, 70000, 1'b1));
	endtask

	// One broken field per encoding; the rest of the bytes are then ignored.
	task automatic test_layout_errors();
		byte_q_t good;
		byte_q_t s;
		good = der_blob('{8'h12, 8'h34, 8'h56, 8'h78}, 0, 0, 1'b0);
		s = good; s[0] = SEQ_TAG_BYTE + 8'd1; send_stream(s);
		// Length control in short form, with no length bytes, and with three.
		s = good; s[1] = 8'h01; send_stream(s);
		s = good; s[1] = LONG_LEN_FLAG; send_stream(s);
		s = good; s[1] = LONG_LEN_FLAG | 8'd3; send_stream(s);
		// Each version byte and the octet tag.
		s = good; s[3] = VER_TAG_BYTE + 8'd1; send_stream(s);
		s = good; s[4] = 8'h00; send_stream(s);
		s = good; s[5] = VER_TAG_BYTE; send_stream(s);
		s = good; s[6] = VER_TAG_BYTE; send_stream(s);
		// Octet length just over the key size, and the largest byte value.
		s = der_blob(rand_key(4), 0, 0, 1'b0); s[7] = KEY_BYTES + 8'd1; send_stream(s);
		s = der_blob(rand_key(4), 1, 0, 1'b0); s[7] = 8'hFF; send_stream(s);
	endtask

	// The final byte arrives before the key is complete.
	task automatic test_short_buffers();
		byte_q_t s;
		send_stream('{SEQ_TAG_BYTE});
		send_stream('{8'h00});
		s = der_blob(rand_key(32), 0, 0, 1'b0);
		repeat (10) void'(s.pop_back());
		send_stream(s);
		s = der_blob(rand_key(5), 0, 0, 1'b1);
		repeat (s.size() - 5) void'(s.pop_back());
		send_stream(s);
	endtask

	// Trailing bytes after the key, two length bytes with a zero high byte,
	// and a two-byte length that overshoots the buffer.
	task automatic test_long_tails();
		send_stream(der_blob(rand_key(6), 3, 0, 1'b0));
		send_stream(der_blob(rand_key(2), 40, 0, 1'b1));
		send_stream(der_blob(rand_key(2), 3, 260, 1'b1));
	endtask

	// One random encoding. Most are well formed with random content; the rest
	// end early, carry one broken header byte, or are plain noise.
	task automatic random_stream(output byte_q_t s);
		byte_q_t key;
		int kind;
		int klen;
		int adj;
		kind = $urandom_range(99);
		klen = ($urandom_range(3) == 0) ? 32 : $urandom_range(8);
		if (kind < 15) key = near_order_key($urandom_range(32));
		else key = rand_key(klen);
		adj = ($urandom_range(5) == 0) ? int'($urandom_range(4)) + 1 : -int'($urandom_range(3));
		s = der_blob(key, $urandom_range(3), adj, 1'($urandom_range(1)));
		if (kind >= 70 && kind < 80) begin
			repeat ($urandom_range(s.size() - 1, 1)) void'(s.pop_back());
		end else if (kind >= 80 && kind < 90) begin
			s[$urandom_range((s.size() > 9) ? 8 : s.size() - 1)] = 8'($urandom_range(255));
		end else if (kind >= 90) begin
			s = {};
			repeat ($urandom_range(12, 1)) s = {s, 8'($urandom_range(255))};
		end
	endtask

	// Four idling phases; each ends with the sender held off until the block
	// has drained, and now and then the sender drains mid-phase as well.
	task automatic test_random_streams();
		byte_q_t s;
		int phase_bytes;
		int phase_streams;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 52; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 52; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			phase_bytes = 0;
			phase_streams = 0;
			while (phase_bytes < 100 || phase_streams < 4) begin
				random_stream(s);
				send_stream(s);
				phase_bytes += s.size();
				phase_streams++;
				if ($urandom_range(19) == 0)
					wait_drained();
			end
			wait_drained();
		end
	endtask

	initial begin
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_accepted_keys();
		test_layout_errors();
		test_short_buffers();
		test_long_tails();
		test_random_streams();
		// Stop sending, let the last result through, then keep the clock running
		// to catch anything the block should not have produced.
		req_valid <= 1'b0;
		while (key_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0) begin
			$display("der_ec_private_key_import_unit: match");
		end else begin
			$display("der_ec_private_key_import_unit: mismatch");
		end
		$finish;
	end

endmodule
